@@ hdl/crc_pkg.sv @@
package crc_pkg;

  // Fixed field and bus widths
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned OUT_TDATA_W = 8;

  // Register map: index of the slot count register, and its reset value
  localparam logic [ADDR_W-3:0] REG_SLOTS_IN_USE = '0;
  localparam logic [CFG_W-1:0]  SLOTS_RESET      = 5'd16;

  typedef enum logic [1:0] {
    OUTCOME_HIT     = 2'd0,
    OUTCOME_FILL    = 2'd1,
    OUTCOME_REPLACE = 2'd2
  } crc_outcome_e;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } crc_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_key;
    logic commit;
  } crc_cmd_t;

  // Datapath to controller: result of the access under way
  typedef struct packed {
    crc_outcome_e            outcome;
    logic [SLOT_W-1:0]       slot;
  } crc_status_t;

endpackage

@@ hdl/clock_replacement_cache_top.sv @@
// Fully associative tag cache with clock (second-chance) replacement. Each key word
// is compared against every valid slot in use; a hit sets the slot's reference bit,
// a miss fills the lowest empty slot, and with no slot empty the hand sweeps from its
// position clearing set reference bits until it finds a clear one, which is replaced.
// The result word gives the outcome (hit, fill, replace) and the slot. An access
// first takes the key word into a register; then the parallel tag compare, the
// empty-slot search, the rotating search over reference bits and the state update
// all complete. The result sits in an output register, so a new key word is taken
// while an earlier result waits; the next update then holds until that result is
// taken. Reset clears valid and reference bits; no clearing pass is needed. The user
// must write the slot count register only while idle; the block does not enforce it.
module clock_replacement_cache_top #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Key words
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [crc_pkg::KEY_W-1:0]         s_axis_tdata,   // [31:0] key
  // Result words
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [crc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // [1:0] outcome, [5:2] slot
  // Configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [crc_pkg::ADDR_W-1:0]        paddr,
  input  logic [crc_pkg::DATA_W-1:0]        pwdata,
  output logic [crc_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import crc_pkg::*;

  logic [CFG_W-1:0] slots_in_use;
  crc_cmd_t         cmd;
  crc_status_t      status;

  crc_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .slots_in_use_o (slots_in_use)
  );

  crc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  crc_dp #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .key_i          (s_axis_tdata),
    .slots_in_use_i (slots_in_use),
    .status_o       (status)
  );

  // One access in flight: a taken key word closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("key word taken while an access was in flight");

  // A new result only follows a lookup cycle
  a_result_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result word raised without a lookup");

  // Update and key capture never coincide
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.load_key && cmd.commit))
    else $error("key capture during state update");

endmodule

@@ hdl/crc_cfg.sv @@
module crc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [crc_pkg::ADDR_W-1:0]   paddr,
  input  logic [crc_pkg::DATA_W-1:0]   pwdata,
  output logic [crc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [crc_pkg::CFG_W-1:0]    slots_in_use_o
);
  import crc_pkg::*;

  logic [ADDR_W-3:0] reg_idx;
  logic              wr_en;
  logic [CFG_W-1:0]  slots_in_use_q;
  logic [CFG_W-1:0]  slots_in_use_d;

  // Decode the word index; byte lanes within a word are ignored
  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Take a write to the slot count
  always_comb begin
    slots_in_use_d = slots_in_use_q;
    if (wr_en && (reg_idx == REG_SLOTS_IN_USE)) begin
      slots_in_use_d = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= SLOTS_RESET;
    end else begin
      slots_in_use_q <= slots_in_use_d;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SLOTS_IN_USE) begin
      prdata = DATA_W'(slots_in_use_q);
    end
  end

  assign slots_in_use_o = slots_in_use_q;

endmodule

@@ hdl/crc_dp.sv @@
module crc_dp #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  crc_pkg::crc_cmd_t          cmd_i,
  input  logic [crc_pkg::KEY_W-1:0]  key_i,
  input  logic [crc_pkg::CFG_W-1:0]  slots_in_use_i,
  output crc_pkg::crc_status_t       status_o
);
  import crc_pkg::*;

  // The slot count register cannot reach past this many slots
  localparam int unsigned MAX_USED = (1 << CFG_W) - 1;
  localparam int unsigned DEPTH    = (ENTRIES < MAX_USED) ? ENTRIES : MAX_USED;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = IDX_W + 1;

  logic [KEY_BITS-1:0] keys_q [DEPTH];
  logic [KEY_BITS-1:0] key_q;
  logic [63:0]         key_wide;
  logic [DEPTH-1:0]    valid_q, valid_d;
  logic [DEPTH-1:0]    ref_q, ref_d;
  logic [IDX_W-1:0]    hand_q, hand_d;

  logic [CNT_W-1:0]    used;
  logic [DEPTH-1:0]    in_use, match, empty, cand, cand_hi, pass;
  logic [IDX_W-1:0]    hit_idx, empty_idx, hi_idx, lo_idx, start, victim;
  logic                hit, any_empty, any_hi, any_lo;
  logic [CNT_W-1:0]    victim_inc;
  logic [IDX_W-1:0]    hand_next;
  logic [IDX_W-1:0]    sel_idx;
  crc_outcome_e        outcome_sel;
  logic [7:0]          slot_wide;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;

  // Hold the key of the access, cut to the tag width
  assign key_wide = 64'(key_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      key_q <= key_wide[KEY_BITS-1:0];
    end
  end

  // Clamp the slot count to 1..DEPTH
  always_comb begin
    if (slots_in_use_i == '0) begin
      used = CNT_W'(1);
    end else if (int'(slots_in_use_i) > int'(DEPTH)) begin
      used = CNT_W'(DEPTH);
    end else begin
      used = CNT_W'(slots_in_use_i);
    end
  end

  // Hand outside the slots in use acts as slot 0
  assign start = (CNT_W'(hand_q) < used) ? hand_q : '0;

  // Per-slot compare and candidate flags
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      in_use[i]  = CNT_W'(i) < used;
      match[i]   = in_use[i] && valid_q[i] && (keys_q[i] == key_q);
      empty[i]   = in_use[i] && !valid_q[i];
      cand[i]    = in_use[i] && !ref_q[i];
      cand_hi[i] = cand[i] && (IDX_W'(i) >= start);
    end
  end

  assign hit       = |match;
  assign any_empty = |empty;
  assign any_hi    = |cand_hi;
  assign any_lo    = |cand;

  // Lowest set position of each vector
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    hi_idx    = '0;
    lo_idx    = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i])   hit_idx   = IDX_W'(i);
      if (empty[i])   empty_idx = IDX_W'(i);
      if (cand_hi[i]) hi_idx    = IDX_W'(i);
      if (cand[i])    lo_idx    = IDX_W'(i);
    end
  end

  // Victim: first clear reference bit from the hand on, wrapping; none clear means
  // a full turn that ends where it started
  always_comb begin
    if (any_hi) begin
      victim = hi_idx;
    end else if (any_lo) begin
      victim = lo_idx;
    end else begin
      victim = start;
    end
  end

  // Slots the sweep passes over before it stops
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (!any_lo) begin
        pass[i] = in_use[i];
      end else if (victim >= start) begin
        pass[i] = in_use[i] && (IDX_W'(i) >= start) && (IDX_W'(i) < victim);
      end else begin
        pass[i] = in_use[i] && ((IDX_W'(i) >= start) || (IDX_W'(i) < victim));
      end
    end
  end

  // Advance the hand past the victim, wrapping at the slot count
  assign victim_inc = CNT_W'(victim) + CNT_W'(1);
  assign hand_next  = (victim_inc >= used) ? '0 : victim_inc[IDX_W-1:0];

  // Outcome of the access
  always_comb begin
    if (hit) begin
      outcome_sel = OUTCOME_HIT;
      sel_idx     = hit_idx;
    end else if (any_empty) begin
      outcome_sel = OUTCOME_FILL;
      sel_idx     = empty_idx;
    end else begin
      outcome_sel = OUTCOME_REPLACE;
      sel_idx     = victim;
    end
  end

  assign slot_wide = 8'(sel_idx);
  assign status_o  = '{outcome: outcome_sel, slot: slot_wide[SLOT_W-1:0]};

  // Next state of valid bits, reference bits and hand
  always_comb begin
    valid_d = valid_q;
    ref_d   = ref_q;
    hand_d  = hand_q;
    wr_en   = 1'b0;
    wr_idx  = sel_idx;
    if (cmd_i.commit) begin
      if (hit) begin
        ref_d[hit_idx] = 1'b1;
      end else if (any_empty) begin
        valid_d[empty_idx] = 1'b1;
        ref_d[empty_idx]   = 1'b0;
        wr_en              = 1'b1;
      end else begin
        ref_d         = ref_q & ~pass;
        ref_d[victim] = 1'b0;
        hand_d        = hand_next;
        wr_en         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ref_q   <= '0;
      hand_q  <= '0;
    end else begin
      valid_q <= valid_d;
      ref_q   <= ref_d;
      hand_q  <= hand_d;
    end
  end

  // Tag store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      keys_q[wr_idx] <= key_q;
    end
  end

endmodule

@@ hdl/crc_ctrl.sv @@
module crc_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_valid_i,
  output logic                              s_ready_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [crc_pkg::OUT_TDATA_W-1:0]   m_data_o,
  input  crc_pkg::crc_status_t              status_i,
  output crc_pkg::crc_cmd_t                 cmd_o
);
  import crc_pkg::*;

  crc_state_e                state_q, state_d;
  logic                      m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0]    m_data_q;
  logic                      out_free;

  // Result register may be loaded when empty or being drained
  assign out_free = !m_valid_q || m_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    s_ready_o    = 1'b0;
    cmd_o.commit = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
      end
      ST_LOOK: begin
        cmd_o.commit = out_free;
      end
      default: begin
        s_ready_o = 1'b0;
      end
    endcase
    cmd_o.load_key = s_valid_i && s_ready_o;
  end

  // Result word valid flag
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.commit) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (cmd_o.commit) begin
      m_data_q <= OUT_TDATA_W'({status_i.slot, status_i.outcome});
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

endmodule

@@ verif/clock_replacement_cache_top_tb.sv @@
`timescale 1ns / 1ps

module clock_replacement_cache_top_tb;
  import crc_pkg::*;

  localparam int unsigned ENTRIES      = 16;
  localparam int unsigned QUIET_CYCLES = 4;
  localparam int unsigned RANDOM_KEYS  = 1330;
  localparam logic [ADDR_W-1:0] SLOTS_ADDR = {REG_SLOTS_IN_USE, 2'b00};

  typedef enum logic [1:0] {
    FEED_KEY,
    FEED_SLOTS,
    FEED_DRAIN
  } feed_kind_e;

  typedef enum logic [2:0] {
    BUS_IDLE,
    BUS_WR_SETUP,
    BUS_WR_ACCESS,
    BUS_RD_SETUP,
    BUS_RD_ACCESS
  } bus_phase_e;

  typedef struct {
    feed_kind_e       kind;
    logic [KEY_W-1:0] payload;
  } feed_t;

  typedef struct {
    crc_outcome_e      outcome;
    logic [SLOT_W-1:0] slot;
  } lookup_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [KEY_W-1:0]       s_axis_tdata = '0;       // [31:0] key
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;           // [1:0] outcome, [5:2] slot
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ADDR_W-1:0]      paddr = '0;
  logic [DATA_W-1:0]      pwdata = '0;
  logic [DATA_W-1:0]      prdata;
  logic                   pready;

  clock_replacement_cache_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the cache state
  logic [KEY_W-1:0] tag_store     [ENTRIES];
  logic             tag_live      [ENTRIES];
  logic             second_chance [ENTRIES];
  int unsigned      clock_hand;
  logic [CFG_W-1:0] slot_limit;

  feed_t       feed_q[$];
  lookup_t     expected_q[$];
  int unsigned fault_cnt = 0;
  int unsigned keys_accepted = 0;
  int unsigned results_taken = 0;
  bit          feed_done = 1'b0;

  // Sender and receiver pacing
  bus_phase_e  bus_phase = BUS_IDLE;
  int unsigned gap_left = 0;
  int unsigned burst_left = 8;
  int unsigned quiet_cnt = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_cnt = 0;
  logic [7:0]  stall_ring = 8'hA5;

  // Apply one access to the shadow cache and queue the result it must give
  function automatic void access_cache(input logic [KEY_W-1:0] key);
    int unsigned n;
    int unsigned i;
    int unsigned p;
    int unsigned turns;
    bit          done;
    lookup_t     res;
    n = (slot_limit == 0) ? 1 : ((slot_limit > ENTRIES) ? ENTRIES : slot_limit);
    done = 1'b0;
    // lowest matching valid slot wins
    for (i = 0; i < n && !done; i++) begin
      if (tag_live[i] && tag_store[i] == key) begin
        second_chance[i] = 1'b1;
        res.outcome = OUTCOME_HIT;
        res.slot = i[SLOT_W-1:0];
        done = 1'b1;
      end
    end
    // otherwise the lowest empty slot; the hand stays put
    for (i = 0; i < n && !done; i++) begin
      if (!tag_live[i]) begin
        tag_live[i] = 1'b1;
        tag_store[i] = key;
        second_chance[i] = 1'b0;
        res.outcome = OUTCOME_FILL;
        res.slot = i[SLOT_W-1:0];
        done = 1'b1;
      end
    end
    // otherwise sweep, giving set slots a second chance
    if (!done) begin
      p = (clock_hand >= n) ? 0 : clock_hand;
      for (turns = 0; turns <= n && second_chance[p]; turns++) begin
        second_chance[p] = 1'b0;
        p = (p + 1 >= n) ? 0 : p + 1;
      end
      tag_store[p] = key;
      second_chance[p] = 1'b0;
      clock_hand = (p + 1 >= n) ? 0 : p + 1;
      res.outcome = OUTCOME_REPLACE;
      res.slot = p[SLOT_W-1:0];
    end
    expected_q.push_back(res);
  endfunction

  function automatic void push_key(input logic [KEY_W-1:0] key);
    feed_t f;
    f.kind = FEED_KEY;
    f.payload = key;
    feed_q.push_back(f);
  endfunction

  function automatic void push_slots(input logic [CFG_W-1:0] count);
    feed_t f;
    f.kind = FEED_SLOTS;
    f.payload = {{(KEY_W-CFG_W){1'b0}}, count};
    feed_q.push_back(f);
  endfunction

  // Driver: key words in bursts, register writes only once the block is idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        access_cache(s_axis_tdata);
        keys_accepted++;
      end
      case (bus_phase)
        BUS_WR_SETUP: begin
          penable <= 1'b1;
          bus_phase = BUS_WR_ACCESS;
        end
        BUS_WR_ACCESS: begin
          if (pready) begin
            if (paddr == SLOTS_ADDR) slot_limit = pwdata[CFG_W-1:0];
            penable <= 1'b0;
            pwrite <= 1'b0;
            bus_phase = BUS_RD_SETUP;
          end
        end
        BUS_RD_SETUP: begin
          penable <= 1'b1;
          bus_phase = BUS_RD_ACCESS;
        end
        BUS_RD_ACCESS: begin
          if (pready) begin
            if (prdata !== {{(DATA_W-CFG_W){1'b0}}, slot_limit}) begin
              $display("%0t: slot count read back expected %h actual %h", $time,
                       slot_limit, prdata);
              fault_cnt++;
            end
            psel <= 1'b0;
            penable <= 1'b0;
            bus_phase = BUS_IDLE;
          end
        end
        default: begin
          if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
              gap_left--;
              s_axis_tvalid <= 1'b0;
            end else if (feed_q.size() == 0) begin
              s_axis_tvalid <= 1'b0;
              feed_done = 1'b1;
            end else if (feed_q[0].kind == FEED_KEY) begin
              s_axis_tvalid <= 1'b1;
              s_axis_tdata <= feed_q[0].payload;
              feed_q.delete(0);
              if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 16);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
              end else begin
                burst_left--;
              end
            end else begin
              // hold the lane quiet until every result is back
              s_axis_tvalid <= 1'b0;
              if (s_axis_tvalid || keys_accepted != results_taken) begin
                quiet_cnt = 0;
              end else if (quiet_cnt < QUIET_CYCLES) begin
                quiet_cnt++;
              end else begin
                quiet_cnt = 0;
                if (feed_q[0].kind == FEED_SLOTS) begin
                  psel <= 1'b1;
                  pwrite <= 1'b1;
                  penable <= 1'b0;
                  paddr <= SLOTS_ADDR;
                  pwdata <= DATA_W'(feed_q[0].payload);
                  bus_phase = BUS_WR_SETUP;
                end
                feed_q.delete(0);
              end
            end
          end
        end
      endcase
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_taken <= results_taken + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result word %h with nothing expected", $time, m_axis_tdata);
          fault_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[1:0] !== want.outcome) begin
            $display("%0t: outcome expected %0d actual %0d", $time, want.outcome,
                     m_axis_tdata[1:0]);
            fault_cnt++;
          end
          if (m_axis_tdata[5:2] !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot,
                     m_axis_tdata[5:2]);
            fault_cnt++;
          end
        end
      end
      // switch stall pattern now and then
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 4);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      stall_ring = {stall_ring[6:0], stall_ring[7]};
      hold_cnt = (hold_cnt == 0) ? 15 : hold_cnt - 1;
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        3: m_axis_tready <= stall_ring[0];
        default: m_axis_tready <= (hold_cnt == 0);
      endcase
      if (mode_left == 0) stall_ring = 8'($urandom_range(1, 255));
    end
  end

  initial begin
    logic [KEY_W-1:0] key_pool [24];
    logic [KEY_W-1:0] k;
    logic [CFG_W-1:0] setting;
    int unsigned      random_keys;
    int unsigned      eff;
    int unsigned      phase_len;
    int unsigned      r;
    int unsigned      j;

    for (j = 0; j < ENTRIES; j++) begin
      tag_store[j] = '0;
      tag_live[j] = 1'b0;
      second_chance[j] = 1'b0;
    end
    clock_hand = 0;
    slot_limit = SLOTS_RESET;

    // Directed: fill, hit, second chance and replace on four slots
    push_slots(5'd4);
    push_key(32'h0000_0000);
    push_key(32'hFFFF_FFFF);
    push_key(32'h0000_0000);
    push_key(32'h5555_5555);
    push_key(32'hAAAA_AAAA);
    push_key(32'h0000_0001);
    push_key(32'hFFFF_FFFF);
    push_key(32'h0000_0000);
    // shrink with the hand beyond the count; pull a parked key into the lower slots
    push_slots(5'd2);
    push_key(32'h0000_0002);
    push_key(32'hAAAA_AAAA);
    // grow again: the key now sits twice, lowest copy must hit; fill leaves the hand
    push_slots(5'd16);
    push_key(32'hAAAA_AAAA);
    push_key(32'h0000_0007);
    // zero slot count behaves as one
    push_slots(5'd0);
    push_key(32'h0000_0009);
    push_key(32'h0000_0009);
    // all reference bits set, so the sweep goes a full turn
    push_slots(5'd3);
    push_key(32'h0000_0015);
    push_key(32'h0000_0016);
    push_key(32'h0000_0017);
    push_key(32'h0000_0015);
    push_key(32'h0000_0016);
    push_key(32'h0000_0017);
    push_key(32'h0000_0018);

    // Random: phases of one slot count each, keys mostly from a small pool
    for (j = 0; j < 24; j++) key_pool[j] = $urandom();
    random_keys = 0;
    while (random_keys < RANDOM_KEYS) begin
      case ($urandom_range(0, 9))
        0: setting = 5'd1;
        1: setting = 5'd16;
        2: setting = 5'd31;
        3: setting = 5'd0;
        4: setting = 5'd17;
        5: setting = 5'd2;
        default: setting = 5'($urandom_range(0, 31));
      endcase
      push_slots(setting);
      eff = (setting == 0) ? 1 : ((setting > ENTRIES) ? ENTRIES : setting);
      for (j = 0; j < 4; j++) key_pool[$urandom_range(0, 23)] = $urandom();
      phase_len = $urandom_range(40, 120);
      for (j = 0; j < phase_len; j++) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          k = key_pool[$urandom_range(0, (eff + 3 > 23) ? 23 : eff + 3)];
        end else if (r < 9) begin
          k = $urandom();
        end else begin
          k = key_pool[$urandom_range(0, 23)];
          k[$urandom_range(0, KEY_W-1)] ^= 1'b1;
        end
        push_key(k);
        random_keys++;
        if ($urandom_range(0, 79) == 0) begin
          feed_q.push_back('{kind: FEED_DRAIN, payload: '0});
        end
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(feed_done && bus_phase == BUS_IDLE && keys_accepted == results_taken))
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_q.size());
      fault_cnt++;
    end
    if (fault_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("%0t: run timed out", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
